[rtl/gss_pkg.sv]
// Shared types and codes for the sequential gearshift sequencer.
// No dependencies; imported by every module of the block.
package gss_pkg;

  // Fixed field widths of the channels
  localparam int unsigned NowW    = 32;
  localparam int unsigned FieldGW = 3;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;

  // Register reset values
  localparam logic [DelayW-1:0]  DelayRst   = 16'd20;
  localparam logic [FieldGW-1:0] TopGearRst = 3'd6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxDelay   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxTopGear = 4'd1;

  typedef enum logic {
    OP_POLL   = 1'b0,
    OP_BUTTON = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    BTN_NEUTRAL     = 3'd0,
    BTN_UP          = 3'd1,
    BTN_DOWN        = 3'd2,
    BTN_OVERRIDE    = 3'd3,
    BTN_DIRECT_UP   = 3'd4,
    BTN_DIRECT_DOWN = 3'd5
  } btn_kind_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_FWD_START = 3'd1,
    CMD_FWD_STOP  = 3'd2,
    CMD_BWD_START = 3'd3,
    CMD_BWD_SLOW  = 3'd4,
    CMD_BWD_STOP  = 3'd5
  } act_cmd_e;

  // One input word
  typedef struct packed {
    logic               opcode;
    logic [NowW-1:0]    now_ms;
    logic [2:0]         button_kind;
    logic [FieldGW-1:0] override_gear;
  } item_t;

  // One result word
  typedef struct packed {
    act_cmd_e           actuator_cmd;
    logic               spark_cut;
    logic [FieldGW-1:0] current_gear;
    logic               commit;
    logic               shifting;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic [DelayW-1:0]  actuator_delay_ms;
    logic [FieldGW-1:0] top_gear;
  } cfg_t;

endpackage

[rtl/gss_cfg_regs.sv]
// Configuration registers of the gearshift sequencer.
// Depends on gss_pkg.
module gss_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [gss_pkg::CfgIdxW-1:0]    wr_idx_i,
  input  logic [gss_pkg::CfgDatW-1:0]    wr_data_i,
  output gss_pkg::cfg_t                  cfg_o
);
  import gss_pkg::*;

  cfg_t cfg_q;

  // Writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.actuator_delay_ms <= DelayRst;
      cfg_q.top_gear          <= TopGearRst;
    end else if (wr_en_i) begin
      if (wr_idx_i == CfgIdxDelay) begin
        cfg_q.actuator_delay_ms <= wr_data_i[DelayW-1:0];
      end
      if (wr_idx_i == CfgIdxTopGear) begin
        cfg_q.top_gear <= wr_data_i[FieldGW-1:0];
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/gss_in_stage.sv]
// Input register of the gearshift sequencer: one word deep.
// Depends on gss_pkg.
module gss_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gss_pkg::item_t in_item_i,
  input  logic           go_i,
  output logic           s1_vld_o,
  output gss_pkg::item_t s1_item_o
);
  import gss_pkg::*;

  logic  vld_q;
  item_t item_q;
  logic  take;

  // Full and not draining this cycle means stall
  assign in_stall_o = vld_q && !go_i;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (go_i) begin
      vld_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign s1_vld_o  = vld_q;
  assign s1_item_o = item_q;

endmodule

[rtl/gss_core.sv]
// Shift state, next-state logic and result register of the sequencer.
// Depends on gss_pkg.
module gss_core #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned GEAR_BITS = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gss_pkg::cfg_t    cfg_i,
  input  logic             s1_vld_i,
  input  gss_pkg::item_t   s1_item_i,
  output logic             go_o,
  output logic             out_vld_o,
  input  logic             out_stall_i,
  output gss_pkg::result_t out_res_o
);
  import gss_pkg::*;

  localparam logic [GEAR_BITS-1:0] GearZero = '0;
  localparam logic [GEAR_BITS-1:0] GearOne  = GEAR_BITS'(1);

  // Architectural state
  logic [GEAR_BITS-1:0] gear_now_q,    gear_now_d;
  logic [GEAR_BITS-1:0] gear_tgt_q,    gear_tgt_d;
  logic                 active_q,      active_d;
  logic [TIME_BITS-1:0] start_q,       start_d;
  logic                 cut_q,         cut_d;

  // Result register
  logic    out_vld_q;
  result_t res_q, res_d;

  logic go;

  // Move the input word through when the result slot is free or draining
  assign go   = s1_vld_i && (!out_vld_q || !out_stall_i);
  assign go_o = go;

  // Next state and result for the word in the input register
  always_comb begin
    logic [TIME_BITS-1:0] now_ext;
    logic [TIME_BITS-1:0] elapsed;
    logic [GEAR_BITS-1:0] top_ext;
    logic [GEAR_BITS-1:0] new_gear;
    act_cmd_e             start_cmd;
    act_cmd_e             stop_cmd;
    act_cmd_e             cmd;
    logic                 committed;

    now_ext   = TIME_BITS'(s1_item_i.now_ms);
    elapsed   = now_ext - start_q;
    top_ext   = GEAR_BITS'(cfg_i.top_gear);
    new_gear  = gear_now_q;
    start_cmd = CMD_NONE;
    stop_cmd  = CMD_NONE;
    cmd       = CMD_NONE;
    committed = 1'b0;

    gear_now_d = gear_now_q;
    gear_tgt_d = gear_tgt_q;
    active_d   = active_q;
    start_d    = start_q;
    cut_d      = cut_q;

    if (op_e'(s1_item_i.opcode) == OP_BUTTON) begin
      unique case (btn_kind_e'(s1_item_i.button_kind))
        BTN_NEUTRAL: gear_tgt_d = GearZero;
        BTN_UP, BTN_DIRECT_UP: begin
          if (gear_tgt_q < top_ext) gear_tgt_d = gear_tgt_q + GearOne;
        end
        BTN_DOWN: begin
          if (gear_tgt_q > GearOne) gear_tgt_d = gear_tgt_q - GearOne;
        end
        BTN_OVERRIDE: begin
          gear_now_d = GEAR_BITS'(s1_item_i.override_gear);
          gear_tgt_d = GEAR_BITS'(s1_item_i.override_gear);
          cut_d      = 1'b0;
          active_d   = 1'b0;
          start_d    = now_ext;
          committed  = 1'b1;
        end
        BTN_DIRECT_DOWN: begin
          if (gear_tgt_q > GearZero) gear_tgt_d = gear_tgt_q - GearOne;
        end
        default: ;  // unused kinds leave the state alone
      endcase
    end else if (gear_tgt_q != gear_now_q) begin
      // Path is picked fresh on every poll
      priority if (gear_tgt_q >= GearOne && gear_now_q == GearZero) begin
        start_cmd = CMD_FWD_START;
        stop_cmd  = CMD_FWD_STOP;
        new_gear  = GearOne;
      end else if (gear_tgt_q == GearZero && gear_now_q == GearOne) begin
        start_cmd = CMD_BWD_SLOW;
        stop_cmd  = CMD_BWD_STOP;
        new_gear  = GearZero;
      end else if (gear_tgt_q > gear_now_q) begin
        start_cmd = CMD_BWD_START;
        stop_cmd  = CMD_BWD_STOP;
        new_gear  = gear_now_q + GearOne;
      end else begin
        start_cmd = CMD_FWD_START;
        stop_cmd  = CMD_FWD_STOP;
        new_gear  = gear_now_q - GearOne;
      end

      if (!active_q) begin
        active_d = 1'b1;
        start_d  = now_ext;
        cut_d    = 1'b1;
        cmd      = start_cmd;
      end else if (elapsed > TIME_BITS'(cfg_i.actuator_delay_ms)) begin
        gear_now_d = new_gear;
        cut_d      = 1'b0;
        active_d   = 1'b0;
        start_d    = now_ext;
        committed  = 1'b1;
        cmd        = stop_cmd;
      end
    end

    res_d.actuator_cmd = cmd;
    res_d.spark_cut    = cut_d;
    res_d.current_gear = gear_now_d[FieldGW-1:0];
    res_d.commit       = committed;
    res_d.shifting     = active_d;
  end

  // State update, one word per cycle while the output is not stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_now_q <= '0;
      gear_tgt_q <= '0;
      active_q   <= 1'b0;
      start_q    <= '0;
      cut_q      <= 1'b0;
    end else if (go) begin
      gear_now_q <= gear_now_d;
      gear_tgt_q <= gear_tgt_d;
      active_q   <= active_d;
      start_q    <= start_d;
      cut_q      <= cut_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (go) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      res_q <= res_d;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_res_o = res_q;

endmodule

[rtl/sequential_gearshift_sequencer.sv]
// Top level of the sequential gearshift sequencer.
// Depends on gss_pkg, gss_cfg_regs, gss_in_stage and gss_core.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one word per event:
//    opcode_i selects a poll or a button event, now_ms_i is the free-running
//    millisecond tick, button_kind_i and override_gear_i qualify buttons.
//  - Output channel (out_valid_o / out_stall_i) returns exactly one word per
//    input word: actuator command, ignition cut level, engaged gear, commit
//    flag and shift-in-progress flag, in input order.
//  - Configuration channel (cfg_valid_i / cfg_ready_o) writes the actuator
//    delay (index 0) and the top gear (index 1); ready is always high.
//    Write only while no word is in flight.
//  - out_valid_o rises once a word has moved from the input register into the
//    result register; one word is accepted per cycle while the output is not
//    stalled, set by the state update in the core.
//  - Reset clears the gear state to neutral, ends any shift, drops the
//    ignition cut and loads the default delay of 20 ms and top gear 6.
//  - A stall on the output holds the result word; one more word waits in
//    the input register, after which in_stall_o goes high.
module sequential_gearshift_sequencer #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned GEAR_BITS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [gss_pkg::NowW-1:0]      now_ms_i,
  input  logic [2:0]                    button_kind_i,
  input  logic [gss_pkg::FieldGW-1:0]   override_gear_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    actuator_cmd_o,
  output logic                          spark_cut_o,
  output logic [gss_pkg::FieldGW-1:0]   current_gear_o,
  output logic                          commit_o,
  output logic                          shifting_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gss_pkg::CfgDatW-1:0]   cfg_data_i
);
  import gss_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s1_item;
  logic    s1_vld;
  logic    go;
  result_t res;

  assign cfg_ready_o = 1'b1;

  gss_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Pack the input word
  assign in_item.opcode        = opcode_i;
  assign in_item.now_ms        = now_ms_i;
  assign in_item.button_kind   = button_kind_i;
  assign in_item.override_gear = override_gear_i;

  gss_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .go_i       (go),
    .s1_vld_o   (s1_vld),
    .s1_item_o  (s1_item)
  );

  gss_core #(
    .TIME_BITS (TIME_BITS),
    .GEAR_BITS (GEAR_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s1_vld_i    (s1_vld),
    .s1_item_i   (s1_item),
    .go_o        (go),
    .out_vld_o   (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  // Unpack the result word
  assign actuator_cmd_o = res.actuator_cmd;
  assign spark_cut_o    = res.spark_cut;
  assign current_gear_o = res.current_gear;
  assign commit_o       = res.commit;
  assign shifting_o     = res.shifting;

  // Ignition cut tracks the shift flag exactly
  a_cut_tracks_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (spark_cut_o == shifting_o))
    else $error("ignition cut differs from shift flag");

  // A stop command always comes with a commit
  a_stop_commits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (actuator_cmd_o == CMD_FWD_STOP || actuator_cmd_o == CMD_BWD_STOP))
      |-> commit_o)
    else $error("stop command without commit");

  // A commit ends the shift
  a_commit_ends_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && commit_o) |-> !shifting_o)
    else $error("commit while still shifting");

  // Input register drains whenever the output slot is free
  a_no_stall_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output slot");

endmodule
